/* src/orect_pkg.sv */
// ----------------------------------------------------------------------------
// orect_pkg
// Shared constants and types for the oriented rectangle overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package orect_pkg;

    // Default angle resolution: 2^ANGLE_BITS is one full turn
    localparam int ANGLE_BITS = 16;
    // Default fraction bits of the sine and cosine values
    localparam int TRIG_FRAC_BITS = 16;

    // Pipeline depth of the quarter-wave sine unit
    localparam int QS_LAT = 8;
    // Start to result, in clock cycles
    localparam int PIPE_LAT = QS_LAT + 8;

    // Number of candidate separating axes and edge vectors
    localparam int NUM_AXES = 4;

    // Sine polynomial, Q30, highest order first
    localparam logic [31:0] HORNER_C [0:5] = '{
        32'd3864, 32'd172272, 32'd5026995,
        32'd85569306, 32'd693598668, 32'd1686629713
    };

    // Quadrant of a binary angle
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

endpackage

`default_nettype wire

/* src/orect_qsin.sv */
// ----------------------------------------------------------------------------
// orect_qsin
// Pipelined quarter-wave sine: sin(pi/2 * r/Q) for r in 0..Q, rounded to
// TRIG_FRAC_BITS fraction bits. One word enters per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module orect_qsin #(
    parameter int ANGLE_BITS     = orect_pkg::ANGLE_BITS,
    parameter int TRIG_FRAC_BITS = orect_pkg::TRIG_FRAC_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic [ANGLE_BITS-2:0]     i_r,
    output logic      [TRIG_FRAC_BITS:0]   o_sin
);

    localparam int QB = ANGLE_BITS - 2;
    localparam int SH = 30 - TRIG_FRAC_BITS;
    localparam logic [32:0] RND = 33'(1) << (29 - TRIG_FRAC_BITS);
    localparam logic [32:0] ONE = 33'(1) << TRIG_FRAC_BITS;
    localparam logic [31:0] HORNER_C0 = orect_pkg::HORNER_C[0];

    logic [31:0] r_u    [0:6];
    logic        r_full [0:6];
    logic [31:0] r_u2   [0:4];
    logic [31:0] r_acc  [0:4];
    logic [TRIG_FRAC_BITS:0] r_sin;

    logic [63:0] usq;
    logic [63:0] hprod [0:4];
    logic [63:0] fprod;
    logic [32:0] rnd;
    logic [32:0] shf;

    // Products of each step
    always_comb begin
        usq = 64'(r_u[0]) * 64'(r_u[0]);
        hprod[0] = 64'(HORNER_C0) * 64'(r_u2[0]);
        for (int k = 1; k < 5; k++) begin
            hprod[k] = 64'(r_acc[k-1]) * 64'(r_u2[k]);
        end
        fprod = 64'(r_acc[4]) * 64'(r_u[6]);
        rnd   = 33'(fprod[63:32]) + RND;
        shf   = rnd >> SH;
    end

    // Advance the sine pipeline
    always_ff @(posedge i_clk) begin
        // take the fraction of a quarter turn as Q0.32
        r_full[0] <= i_r[QB];
        r_u[0]    <= 32'(i_r[QB-1:0]) << (32 - QB);
        // square it
        r_u2[0]   <= usq[63:32];
        r_u[1]    <= r_u[0];
        r_full[1] <= r_full[0];
        // Horner steps
        for (int k = 0; k < 5; k++) begin
            r_acc[k]    <= orect_pkg::HORNER_C[k+1] - hprod[k][63:32];
            r_u[k+2]    <= r_u[k+1];
            r_full[k+2] <= r_full[k+1];
        end
        for (int k = 1; k < 5; k++) begin
            r_u2[k] <= r_u2[k-1];
        end
        // round, clamp to one
        if (r_full[6] || shf > ONE) begin
            r_sin <= ONE[TRIG_FRAC_BITS:0];
        end else begin
            r_sin <= shf[TRIG_FRAC_BITS:0];
        end
    end

    assign o_sin = r_sin;

endmodule

`default_nettype wire

/* src/oriented_rect_overlap_test.sv */
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test
// Separating axis overlap test for two rotated rectangles in fixed point.
// ----------------------------------------------------------------------------
// Takes one rectangle pair per clock cycle: busy stays low, so every cycle
// with start high is a new word. The answer appears on o_overlapping with
// o_done high for one cycle, in input order. The path runs through the
// input register, the eight-stage sine polynomial pipeline and seven
// stages of quadrant fold, projection, magnitude, radius multiply, partial
// product join, pair sum and compare. Touching rectangles count as
// overlapping, and an edge of zero length gives no separating axis.
`default_nettype none

module oriented_rect_overlap_test #(
    parameter int ANGLE_BITS     = orect_pkg::ANGLE_BITS,
    parameter int TRIG_FRAC_BITS = orect_pkg::TRIG_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [23:0] i_a_center_x,
    input  wire logic signed [23:0] i_a_center_y,
    input  wire logic        [23:0] i_a_width,
    input  wire logic        [23:0] i_a_height,
    input  wire logic        [15:0] i_a_angle,
    input  wire logic signed [23:0] i_b_center_x,
    input  wire logic signed [23:0] i_b_center_y,
    input  wire logic        [23:0] i_b_width,
    input  wire logic        [23:0] i_b_height,
    input  wire logic        [15:0] i_b_angle,
    output logic                    o_done,
    output logic                    o_overlapping
);

    localparam int NA     = orect_pkg::NUM_AXES;
    localparam int LAT    = orect_pkg::PIPE_LAT;
    localparam int QL     = orect_pkg::QS_LAT;
    localparam int QB     = ANGLE_BITS - 2;
    localparam int R_W    = QB + 1;
    localparam int SIN_W  = TRIG_FRAC_BITS + 1;
    localparam int TW     = TRIG_FRAC_BITS + 2;
    localparam int DX_W   = 25;
    localparam int PD_W   = DX_W + TW;
    localparam int LHS_W  = PD_W + 1 + TRIG_FRAC_BITS + 1;
    localparam int PP_W   = 2 * TW;
    localparam int MW     = 2 * TW + 1;
    localparam int MH     = MW / 2;
    localparam int RAD_W  = 24 + MW;
    localparam int CMP_W  = (RAD_W + 2 > LHS_W) ? RAD_W + 2 : LHS_W;
    localparam logic [R_W-1:0] QUARTER = R_W'(1) << QB;

    typedef struct packed {
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic [NA-1:0][23:0]    sz;
        logic [1:0]             qa;
        logic [1:0]             qb;
    } t_geom;

    logic [ANGLE_BITS-1:0] ang_a;
    logic [ANGLE_BITS-1:0] ang_b;
    logic                  accept;

    logic                  r_vld [0:LAT-1];
    t_geom                 r_geo [0:QL+3];
    logic [R_W-1:0]        r_ra_lo;
    logic [R_W-1:0]        r_ra_hi;
    logic [R_W-1:0]        r_rb_lo;
    logic [R_W-1:0]        r_rb_hi;
    logic [SIN_W-1:0]      sa_lo;
    logic [SIN_W-1:0]      sa_hi;
    logic [SIN_W-1:0]      sb_lo;
    logic [SIN_W-1:0]      sb_hi;

    logic signed [TW-1:0]  n_ca, n_sa, n_cb, n_sb;
    logic signed [TW-1:0]  r_ca, r_sa, r_cb, r_sb;
    logic signed [TW-1:0]  ex [0:NA-1];
    logic signed [TW-1:0]  ey [0:NA-1];

    logic signed [PP_W-1:0] r_px  [0:NA-1][0:NA-1];
    logic signed [PP_W-1:0] r_py  [0:NA-1][0:NA-1];
    logic signed [PD_W-1:0] r_pdx [0:NA-1];
    logic signed [PD_W-1:0] r_pdy [0:NA-1];

    logic signed [MW-1:0]   dot [0:NA-1][0:NA-1];
    logic signed [PD_W:0]   dn  [0:NA-1];
    logic [MW-1:0]          r_md  [0:NA-1][0:NA-1];
    logic [PD_W:0]          r_mdn [0:NA-1];

    logic [24+MH-1:0]       r_pl  [0:NA-1][0:NA-1];
    logic [24+MW-MH-1:0]    r_ph  [0:NA-1][0:NA-1];
    logic [LHS_W-1:0]       r_lhs12 [0:NA-1];
    logic [LHS_W-1:0]       r_lhs13 [0:NA-1];
    logic [LHS_W-1:0]       r_lhs14 [0:NA-1];
    logic [NA-1:0]          r_nz12, r_nz13, r_nz14;

    logic [RAD_W-1:0]       r_rad  [0:NA-1][0:NA-1];
    logic [RAD_W:0]         r_pair [0:NA-1][0:1];
    logic [CMP_W-1:0]       total  [0:NA-1];
    logic [NA-1:0]          no_gap;
    logic                   r_ovl;

    // The pipeline never holds a word back
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign ang_a  = ANGLE_BITS'(i_a_angle);
    assign ang_b  = ANGLE_BITS'(i_b_angle);

    // Carry the valid bits down the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Register the word: centre difference, sizes, angle parts
    always_ff @(posedge i_clk) begin
        r_geo[0].dx <= DX_W'(i_b_center_x) - DX_W'(i_a_center_x);
        r_geo[0].dy <= DX_W'(i_b_center_y) - DX_W'(i_a_center_y);
        r_geo[0].sz <= {i_b_height, i_b_width, i_a_height, i_a_width};
        r_geo[0].qa <= ang_a[ANGLE_BITS-1 -: 2];
        r_geo[0].qb <= ang_b[ANGLE_BITS-1 -: 2];
        r_ra_lo     <= {1'b0, ang_a[QB-1:0]};
        r_ra_hi     <= QUARTER - {1'b0, ang_a[QB-1:0]};
        r_rb_lo     <= {1'b0, ang_b[QB-1:0]};
        r_rb_hi     <= QUARTER - {1'b0, ang_b[QB-1:0]};
        for (int k = 1; k <= QL + 3; k++) begin
            r_geo[k] <= r_geo[k-1];
        end
    end

    // Quarter-wave sines, one lane per angle and phase
    orect_qsin #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sa_lo (
        .i_clk (i_clk), .i_r (r_ra_lo), .o_sin (sa_lo)
    );
    orect_qsin #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sa_hi (
        .i_clk (i_clk), .i_r (r_ra_hi), .o_sin (sa_hi)
    );
    orect_qsin #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sb_lo (
        .i_clk (i_clk), .i_r (r_rb_lo), .o_sin (sb_lo)
    );
    orect_qsin #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sb_hi (
        .i_clk (i_clk), .i_r (r_rb_hi), .o_sin (sb_hi)
    );

    // Fold the quadrant into sine and cosine
    always_comb begin
        logic signed [TW-1:0] al, ah, bl, bh;
        al = signed'({1'b0, sa_lo});
        ah = signed'({1'b0, sa_hi});
        bl = signed'({1'b0, sb_lo});
        bh = signed'({1'b0, sb_hi});
        unique case (orect_pkg::t_quad'(r_geo[QL].qa))
            orect_pkg::QUAD_0: begin n_sa = al;  n_ca = ah;  end
            orect_pkg::QUAD_1: begin n_sa = ah;  n_ca = -al; end
            orect_pkg::QUAD_2: begin n_sa = -al; n_ca = -ah; end
            default:           begin n_sa = -ah; n_ca = al;  end
        endcase
        unique case (orect_pkg::t_quad'(r_geo[QL].qb))
            orect_pkg::QUAD_0: begin n_sb = bl;  n_cb = bh;  end
            orect_pkg::QUAD_1: begin n_sb = bh;  n_cb = -bl; end
            orect_pkg::QUAD_2: begin n_sb = -bl; n_cb = -bh; end
            default:           begin n_sb = -bh; n_cb = bl;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ca <= n_ca;
        r_sa <= n_sa;
        r_cb <= n_cb;
        r_sb <= n_sb;
    end

    // Local axes: x and y of each rectangle
    always_comb begin
        ex[0] = r_ca;  ey[0] = r_sa;
        ex[1] = -r_sa; ey[1] = r_ca;
        ex[2] = r_cb;  ey[2] = r_sb;
        ex[3] = -r_sb; ey[3] = r_cb;
    end

    // Project edges and centre difference onto each axis
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            r_pdx[i] <= r_geo[QL+1].dx * ex[i];
            r_pdy[i] <= r_geo[QL+1].dy * ey[i];
            for (int j = 0; j < NA; j++) begin
                r_px[i][j] <= ex[j] * ex[i];
                r_py[i][j] <= ey[j] * ey[i];
            end
        end
    end

    // Sum the projection terms
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            dn[i] = (PD_W+1)'(r_pdx[i]) + (PD_W+1)'(r_pdy[i]);
            for (int j = 0; j < NA; j++) begin
                dot[i][j] = MW'(r_px[i][j]) + MW'(r_py[i][j]);
            end
        end
    end

    // Take magnitudes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            r_mdn[i] <= dn[i][PD_W] ? (PD_W+1)'(-dn[i]) : (PD_W+1)'(dn[i]);
            for (int j = 0; j < NA; j++) begin
                r_md[i][j] <= dot[i][j][MW-1] ? MW'(-dot[i][j]) : MW'(dot[i][j]);
            end
        end
    end

    // Scale by edge lengths in two partial products; scale the distance
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NA; i++) begin
            r_lhs12[i] <= LHS_W'(r_mdn[i]) << (TRIG_FRAC_BITS + 1);
            r_nz12[i]  <= (r_geo[QL+3].sz[i] != 24'd0);
            for (int j = 0; j < NA; j++) begin
                r_pl[i][j] <= (24+MH)'(r_geo[QL+3].sz[j]) * (24+MH)'(r_md[i][j][MH-1:0]);
                r_ph[i][j] <= (24+MW-MH)'(r_geo[QL+3].sz[j])
                            * (24+MW-MH)'(r_md[i][j][MW-1:MH]);
            end
        end
    end

    // Join the partial products
    always_ff @(posedge i_clk) begin
        r_nz13 <= r_nz12;
        for (int i = 0; i < NA; i++) begin
            r_lhs13[i] <= r_lhs12[i];
            for (int j = 0; j < NA; j++) begin
                r_rad[i][j] <= RAD_W'(r_pl[i][j]) + (RAD_W'(r_ph[i][j]) << MH);
            end
        end
    end

    // Add radii in pairs
    always_ff @(posedge i_clk) begin
        r_nz14 <= r_nz13;
        for (int i = 0; i < NA; i++) begin
            r_lhs14[i]   <= r_lhs13[i];
            r_pair[i][0] <= (RAD_W+1)'(r_rad[i][0]) + (RAD_W+1)'(r_rad[i][1]);
            r_pair[i][1] <= (RAD_W+1)'(r_rad[i][2]) + (RAD_W+1)'(r_rad[i][3]);
        end
    end

    // Compare on every axis; drop axes from zero-length edges
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            total[i]  = CMP_W'(r_pair[i][0]) + CMP_W'(r_pair[i][1]);
            no_gap[i] = !r_nz14[i] || (CMP_W'(r_lhs14[i]) <= total[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovl <= &no_gap;
    end

    assign o_done        = r_vld[LAT-1];
    assign o_overlapping = r_ovl;

endmodule

`default_nettype wire

/* src/orect_checker.sv */
// ----------------------------------------------------------------------------
// orect_checker
// Port-level checks for the oriented rectangle overlap test, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module orect_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic signed [23:0] i_a_center_x,
    input wire logic signed [23:0] i_a_center_y,
    input wire logic signed [23:0] i_b_center_x,
    input wire logic signed [23:0] i_b_center_y,
    input wire logic               o_done,
    input wire logic               o_overlapping
);

    // Never refuse a word once out of reset
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised");

    // Every accepted word gives a result on o_done
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(orect_pkg::PIPE_LAT) o_done)
        else $error("result missing");

    // No result without a word taken earlier
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, orect_pkg::PIPE_LAT))
        else $error("spurious result");

    // Shared centres always overlap
    a_same_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_a_center_x == i_b_center_x && i_a_center_y == i_b_center_y)
        |-> ##(orect_pkg::PIPE_LAT) o_overlapping)
        else $error("shared centres reported apart");

endmodule

bind oriented_rect_overlap_test orect_checker u_orect_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_a_center_x  (i_a_center_x),
    .i_a_center_y  (i_a_center_y),
    .i_b_center_x  (i_b_center_x),
    .i_b_center_y  (i_b_center_y),
    .o_done        (o_done),
    .o_overlapping (o_overlapping)
);

`default_nettype wire
